@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SODF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sodf check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SODF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sodf check failed");

`endif

@@ sv/sodf_pkg.sv @@
// Package: shared types, datapath operation codes, register indexes and fixed-point helpers.
`default_nettype none

package sodf_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE    = 2'd2;

	// Reset value of the inverse inertia register: 1.0 in Q16.16
	localparam logic [31:0] INV_INERTIA_RST = 32'h0001_0000;

	// Radix-4 divider: 48 quotient bits, two per step
	localparam logic [4:0] DIV_STEPS = 5'd24;

	// Datapath operations, one per controller step
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE     = 5'd0;
	localparam op_t OP_LOAD     = 5'd1;
	localparam op_t OP_RESTART  = 5'd2;
	localparam op_t OP_DIV_INIT = 5'd3;
	localparam op_t OP_DIV_STEP = 5'd4;
	localparam op_t OP_VIN      = 5'd5;
	localparam op_t OP_MUL_VDT  = 5'd6;
	localparam op_t OP_NPOS     = 5'd7;
	localparam op_t OP_MUL_K3   = 5'd8;
	localparam op_t OP_ACC_K3   = 5'd9;
	localparam op_t OP_MUL_K1   = 5'd10;
	localparam op_t OP_ACC_K1   = 5'd11;
	localparam op_t OP_NUM      = 5'd12;
	localparam op_t OP_MUL_II   = 5'd13;
	localparam op_t OP_ACCEL    = 5'd14;
	localparam op_t OP_MUL_AHI  = 5'd15;
	localparam op_t OP_ACC_AHI  = 5'd16;
	localparam op_t OP_MUL_ALO  = 5'd17;
	localparam op_t OP_ACC_ALO  = 5'd18;
	localparam op_t OP_DVEL     = 5'd19;
	localparam op_t OP_COMMIT   = 5'd20;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic restart;
	} stat_t;

	// Divide a product by 65536, truncating toward zero
	function automatic logic signed [49:0] tdiv_q(input logic signed [65:0] x);
		logic signed [65:0] y;
		y = x + (x[65] ? 66'sd65535 : 66'sd0);
		return y[65:16];
	endfunction

	// True when a 51-bit value does not fit in signed 32 bits
	function automatic logic ovf32(input logic [50:0] v);
		return !((&v[50:31]) || (~|v[50:31]));
	endfunction

	// Clamp a 51-bit value to signed 32 bits
	function automatic logic [31:0] sat32(input logic [50:0] v);
		logic [31:0] r;
		if (ovf32(v)) begin
			r = v[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/sodf_channels_if.sv @@
// Channel interfaces: sample input, result output and configuration write.
`default_nettype none

interface sodf_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target;
	logic        [15:0] time_step;
	logic               restart;

	modport source (output valid, output target, output time_step, output restart, input ready);
	modport sink   (input valid, input target, input time_step, input restart, output ready);
endinterface

interface sodf_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic               saturated;

	modport source (output valid, output position, output saturated, input ready);
	modport sink   (input valid, input position, input saturated, output ready);
endinterface

interface sodf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/sodf_datapath.sv @@
// Datapath: coefficient and state registers, radix-4 divider, shared multiplier, adders.
`default_nettype none

module sodf_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sodf_pkg::cmd_t                  cmd,
	output sodf_pkg::stat_t                      stat,
	input  wire logic signed [31:0]              in_target,
	input  wire logic [15:0]                     in_time_step,
	input  wire logic                            in_restart,
	input  wire logic                            cfg_we,
	input  wire logic [sodf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                     cfg_data,
	output logic signed [31:0]                   position,
	output logic                                 saturated
);
	import sodf_pkg::*;

	// Coefficients
	logic [31:0] k1_q;
	logic [31:0] ii_q;
	logic [31:0] k3_q;

	// Follower state
	logic [31:0] pos_q;
	logic [31:0] vel_q;
	logic [31:0] prev_q;

	// Current request and working registers
	logic [31:0]        tgt_q;
	logic [15:0]        dt_q;
	logic               restart_q;
	logic               neg_q;
	logic [47:0]        quo_q;
	logic [15:0]        rem_q;
	logic [31:0]        vin_q;
	logic [31:0]        npos_q;
	logic               sat_q;
	logic [50:0]        acc_q;
	logic [31:0]        num_q;
	logic [48:0]        accel_q;
	logic signed [65:0] acc2_q;
	logic [49:0]        dv_q;
	logic signed [65:0] prod_q;
	logic [31:0]        position_q;
	logic               saturated_q;

	// Combinational terms
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [49:0]        prod_div;
	logic [49:0]        acc2_div;
	logic [32:0]        diff;
	logic [32:0]        mag;
	logic [16:0]        sh1, sh2, sub1, sub2;
	logic               ge1, ge2;
	logic [15:0]        r1, r2;
	logic [50:0]        quo_ext;
	logic [50:0]        vin_ext;
	logic [50:0]        npos_sum;
	logic [50:0]        k3_sum;
	logic [50:0]        k1_sum;
	logic [50:0]        vel_sum;

	assign stat.restart = restart_q;
	assign position     = position_q;
	assign saturated    = saturated_q;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_VDT: begin
				mul_a = {vel_q[31], vel_q};
				mul_b = {17'b0, dt_q};
			end
			OP_MUL_K3: begin
				mul_a = {k3_q[31], k3_q};
				mul_b = {vin_q[31], vin_q};
			end
			OP_MUL_K1: begin
				mul_a = {1'b0, k1_q};
				mul_b = {vel_q[31], vel_q};
			end
			OP_MUL_II: begin
				mul_a = {num_q[31], num_q};
				mul_b = {1'b0, ii_q};
			end
			OP_MUL_AHI: begin
				mul_a = {accel_q[48], accel_q[48:17]};
				mul_b = {17'b0, dt_q};
			end
			OP_MUL_ALO: begin
				mul_a = {16'b0, accel_q[16:0]};
				mul_b = {17'b0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Scaling, divider step and sums
	always_comb begin
		prod_div = tdiv_q(prod_q);
		acc2_div = tdiv_q(acc2_q);

		diff = {tgt_q[31], tgt_q} - {prev_q[31], prev_q};
		mag  = diff[32] ? (33'd0 - diff) : diff;

		// two restoring steps per cycle
		sh1  = {rem_q, quo_q[47]};
		sub1 = sh1 - {1'b0, dt_q};
		ge1  = (sh1 >= {1'b0, dt_q});
		r1   = ge1 ? sub1[15:0] : sh1[15:0];
		sh2  = {r1, quo_q[46]};
		sub2 = sh2 - {1'b0, dt_q};
		ge2  = (sh2 >= {1'b0, dt_q});
		r2   = ge2 ? sub2[15:0] : sh2[15:0];

		quo_ext  = {3'b0, quo_q};
		vin_ext  = neg_q ? (51'd0 - quo_ext) : quo_ext;

		npos_sum = {{19{pos_q[31]}}, pos_q} + {prod_div[49], prod_div};
		k3_sum   = {{19{tgt_q[31]}}, tgt_q} + {prod_div[49], prod_div}
			- {{19{npos_q[31]}}, npos_q};
		k1_sum   = acc_q - {prod_div[49], prod_div};
		vel_sum  = {{19{vel_q[31]}}, vel_q} + {dv_q[49], dv_q};
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			ii_q <= INV_INERTIA_RST;
			k3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DAMPING:     k1_q <= cfg_data;
				CFG_INV_INERTIA: ii_q <= cfg_data;
				CFG_RESPONSE:    k3_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			vel_q  <= '0;
			prev_q <= '0;
		end else begin
			case (cmd.op)
				OP_RESTART: begin
					pos_q  <= tgt_q;
					vel_q  <= '0;
					prev_q <= tgt_q;
				end
				OP_COMMIT: begin
					pos_q  <= npos_q;
					vel_q  <= sat32(vel_sum);
					prev_q <= tgt_q;
				end
				default: ;
			endcase
		end
	end

	// Request flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			restart_q <= in_restart;
		end
	end

	// Working registers and output register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				tgt_q <= in_target;
				dt_q  <= in_time_step;
			end
			OP_RESTART: begin
				position_q  <= tgt_q;
				saturated_q <= 1'b0;
			end
			OP_DIV_INIT: begin
				neg_q <= diff[32];
				quo_q <= {mag[31:0], 16'b0};
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				quo_q <= {quo_q[45:0], ge1, ge2};
				rem_q <= r2;
			end
			OP_VIN: begin
				vin_q <= (dt_q == 16'd0) ? 32'd0 : sat32(vin_ext);
			end
			OP_NPOS: begin
				npos_q <= sat32(npos_sum);
				sat_q  <= ovf32(npos_sum);
			end
			OP_ACC_K3: acc_q   <= k3_sum;
			OP_ACC_K1: acc_q   <= k1_sum;
			OP_NUM:    num_q   <= sat32(acc_q);
			OP_ACCEL:  accel_q <= prod_div[48:0];
			OP_ACC_AHI: acc2_q <= {prod_q[48:0], 17'b0};
			OP_ACC_ALO: acc2_q <= acc2_q + prod_q;
			OP_DVEL:   dv_q    <= acc2_div;
			OP_COMMIT: begin
				position_q  <= npos_q;
				saturated_q <= sat_q | ovf32(vel_sum);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/sodf_ctrl.sv @@
// Controller: step sequencer, divider step count and output valid.
`default_nettype none

module sodf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire sodf_pkg::stat_t stat,
	output sodf_pkg::cmd_t       cmd
);
	import sodf_pkg::*;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_DIV_INIT = 5'd1;
	localparam logic [4:0] ST_RESTART  = 5'd2;
	localparam logic [4:0] ST_DIV      = 5'd3;
	localparam logic [4:0] ST_VIN      = 5'd4;
	localparam logic [4:0] ST_MUL_VDT  = 5'd5;
	localparam logic [4:0] ST_NPOS     = 5'd6;
	localparam logic [4:0] ST_MUL_K3   = 5'd7;
	localparam logic [4:0] ST_ACC_K3   = 5'd8;
	localparam logic [4:0] ST_MUL_K1   = 5'd9;
	localparam logic [4:0] ST_ACC_K1   = 5'd10;
	localparam logic [4:0] ST_NUM      = 5'd11;
	localparam logic [4:0] ST_MUL_II   = 5'd12;
	localparam logic [4:0] ST_ACCEL    = 5'd13;
	localparam logic [4:0] ST_MUL_AHI  = 5'd14;
	localparam logic [4:0] ST_ACC_AHI  = 5'd15;
	localparam logic [4:0] ST_MUL_ALO  = 5'd16;
	localparam logic [4:0] ST_ACC_ALO  = 5'd17;
	localparam logic [4:0] ST_DVEL     = 5'd18;
	localparam logic [4:0] ST_COMMIT   = 5'd19;

	logic [4:0] state_q, state_d;
	logic [4:0] count_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       publish;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign publish   = (cmd.op == OP_COMMIT) || (cmd.op == OP_RESTART);

	// Next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				state_d = stat.restart ? ST_RESTART : ST_DIV;
			end
			ST_RESTART: begin
				if (slot_free) begin
					cmd.op  = OP_RESTART;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (count_q == DIV_STEPS - 5'd1) begin
					state_d = ST_VIN;
				end
			end
			ST_VIN:     begin cmd.op = OP_VIN;     state_d = ST_MUL_VDT; end
			ST_MUL_VDT: begin cmd.op = OP_MUL_VDT; state_d = ST_NPOS;    end
			ST_NPOS:    begin cmd.op = OP_NPOS;    state_d = ST_MUL_K3;  end
			ST_MUL_K3:  begin cmd.op = OP_MUL_K3;  state_d = ST_ACC_K3;  end
			ST_ACC_K3:  begin cmd.op = OP_ACC_K3;  state_d = ST_MUL_K1;  end
			ST_MUL_K1:  begin cmd.op = OP_MUL_K1;  state_d = ST_ACC_K1;  end
			ST_ACC_K1:  begin cmd.op = OP_ACC_K1;  state_d = ST_NUM;     end
			ST_NUM:     begin cmd.op = OP_NUM;     state_d = ST_MUL_II;  end
			ST_MUL_II:  begin cmd.op = OP_MUL_II;  state_d = ST_ACCEL;   end
			ST_ACCEL:   begin cmd.op = OP_ACCEL;   state_d = ST_MUL_AHI; end
			ST_MUL_AHI: begin cmd.op = OP_MUL_AHI; state_d = ST_ACC_AHI; end
			ST_ACC_AHI: begin cmd.op = OP_ACC_AHI; state_d = ST_MUL_ALO; end
			ST_MUL_ALO: begin cmd.op = OP_MUL_ALO; state_d = ST_ACC_ALO; end
			ST_ACC_ALO: begin cmd.op = OP_ACC_ALO; state_d = ST_DVEL;    end
			ST_DVEL:    begin cmd.op = OP_DVEL;    state_d = ST_COMMIT;  end
			ST_COMMIT: begin
				if (slot_free) begin
					cmd.op  = OP_COMMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, divider count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				count_q <= count_q + 5'd1;
			end else begin
				count_q <= '0;
			end
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/second_order_dynamics_follower.sv @@
// Top level: second-order dynamics follower, controller plus datapath.
//
// Usage:
//   sample  - request carries target (Q16.16), time_step (Q0.16) and restart.
//   result  - request carries the new position (Q16.16) and the saturated flag.
//   cfg     - register writes, always ready: index 0 damping, 1 inverse
//             inertia, 2 response; other indexes are dropped. Write only
//             while the block is idle.
// Sequence:
//   A normal request runs through the radix-4 time step divider and then
//   the update steps, where the single 33x33 multiplier serves six
//   products in turn; its result is registered at the commit step. The
//   next request is taken only once the block is back in idle.
//   A restart request skips both and publishes the target as position.
// Reset clears position, velocity and previous target to zero and loads
// the coefficient reset values; no result is pending after reset.
// One result register sits at the output. A new request is taken while a
// result waits there; if the receiver still stalls when the next result is
// done, the sequencer holds in its last step until the register frees up.
`default_nettype none

module second_order_dynamics_follower (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sodf_sample_if.sink   sample,
	sodf_result_if.source result,
	sodf_cfg_if.sink      cfg
);
	import sodf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	sodf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sodf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_target    (sample.target),
		.in_time_step (sample.time_step),
		.in_restart   (sample.restart),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.position     (result.position),
		.saturated    (result.saturated)
	);

endmodule

`default_nettype wire

@@ sv/sodf_checker.sv @@
// Port-level checker for the follower, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sodf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               sample_valid,
	input wire logic               sample_ready,
	input wire logic               sample_restart,
	input wire logic signed [31:0] sample_target,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic signed [31:0] result_position,
	input wire logic               result_saturated
);

	// a stalled result holds
	`SODF_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_position) && $stable(result_saturated))

	// the block is busy right after taking a request
	`SODF_ASSERT_NXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready)

	// a new result comes together with the return to idle
	`SODF_ASSERT_IMP(a_idle_on_result, $rose(result_valid), sample_ready)

	// restart with an empty output: position equals the target, no clamp
	`SODF_ASSERT_NXT(a_restart_result, sample_valid && sample_ready && sample_restart && !result_valid, ##2 (result_valid && result_position == $past(sample_target, 3) && !result_saturated))

endmodule

bind second_order_dynamics_follower sodf_checker u_sodf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample.valid),
	.sample_ready     (sample.ready),
	.sample_restart   (sample.restart),
	.sample_target    (sample.target),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_position  (result.position),
	.result_saturated (result.saturated)
);

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the second-order dynamics follower: stimulus, predictor and result checker.
`default_nettype none

module tb;
	import sodf_pkg::*;

	localparam longint Q_ONE          = 64'sd65536;
	localparam longint S32_HI         = 64'sd2147483647;
	localparam longint S32_LO         = -64'sd2147483648;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     LONG_HOLD      = 400;
	localparam int     SETTLE_CYCLES  = 60;
	localparam int     PHASE_SAMPLES  = 250;
	localparam int     NUM_PHASES     = 8;
	// Index 3 is decoded by nobody; writes there must leave the gains alone
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [31:0] target;
		logic        [15:0] time_step;
		logic               restart;
	} sample_req_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic               saturated;
	} follow_result_t;

	typedef enum logic [1:0] {RCV_STEADY, RCV_COIN, RCV_THIRD} rcv_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sodf_sample_if sample_ch ();
	sodf_result_if result_ch ();
	sodf_cfg_if    cfg_ch ();

	second_order_dynamics_follower dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Follower state and gains as the block should hold them
	longint fol_position     = 0;
	longint fol_velocity     = 0;
	longint last_target      = 0;
	longint gain_damping     = 0;
	longint gain_inv_inertia = longint'(INV_INERTIA_RST);
	longint gain_response    = 0;

	sample_req_t    pending_samples[$];
	follow_result_t expected_positions[$];
	sample_req_t    offered;
	follow_result_t due_result;

	int failures         = 0;
	int queued_samples   = 0;
	int samples_taken    = 0;
	int restarts_taken   = 0;
	int zero_steps_taken = 0;
	int results_checked  = 0;
	int saturated_seen   = 0;
	int register_writes  = 0;
	int quiet_cycles     = 0;

	function automatic longint clamp_s32(input longint v);
		if (v > S32_HI)
			return S32_HI;
		if (v < S32_LO)
			return S32_LO;
		return v;
	endfunction

	// One semi-implicit Euler step; updates the follower state
	function automatic follow_result_t advance_follower(input sample_req_t s);
		follow_result_t r;
		longint tgt, dt, rate, pos_raw, pos_next, force_term, accel, vel_raw, vel_next;
		tgt = longint'($signed(s.target));
		dt  = longint'(s.time_step);
		if (s.restart) begin
			fol_position = tgt;
			fol_velocity = 0;
			last_target  = tgt;
			r.position   = s.target;
			r.saturated  = 1'b0;
			return r;
		end
		// target speed by finite difference; clamping here and on the force is silent
		rate = (dt != 0) ? clamp_s32(((tgt - last_target) * Q_ONE) / dt) : 64'sd0;
		pos_raw  = fol_position + (fol_velocity * dt) / Q_ONE;
		pos_next = clamp_s32(pos_raw);
		force_term = clamp_s32(tgt + (gain_response * rate) / Q_ONE - pos_next
			- (gain_damping * fol_velocity) / Q_ONE);
		accel    = (force_term * gain_inv_inertia) / Q_ONE;
		vel_raw  = fol_velocity + (accel * dt) / Q_ONE;
		vel_next = clamp_s32(vel_raw);
		r.position  = pos_next[31:0];
		r.saturated = (pos_raw != pos_next) || (vel_raw != vel_next);
		fol_position = pos_next;
		fol_velocity = vel_next;
		last_target  = tgt;
		return r;
	endfunction

	task automatic queue_sample(input logic signed [31:0] t, input logic [15:0] dt,
			input logic rs);
		sample_req_t s;
		s.target    = t;
		s.time_step = dt;
		s.restart   = rs;
		pending_samples.push_back(s);
		queued_samples++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_DAMPING:     gain_damping     = longint'(value);
			CFG_INV_INERTIA: gain_inv_inertia = longint'(value);
			CFG_RESPONSE:    gain_response    = longint'($signed(value));
			default: ;
		endcase
		register_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// Sender stops offering until the block has answered everything
	task automatic wait_until_idle();
		while (pending_samples.size() != 0 || sample_ch.valid || expected_positions.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_gains(input logic [31:0] k1, input logic [31:0] inv_k2,
			input logic [31:0] k3);
		write_register(CFG_DAMPING, k1);
		write_register(CFG_INV_INERTIA, inv_k2);
		write_register(CFG_RESPONSE, k3);
		write_register(CFG_UNUSED, $urandom);
	endtask

	// Sample driver: bursts of requests with random gaps
	int burst_left = 0;
	int gap_left   = 0;
	logic next_valid;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid     <= 1'b0;
			sample_ch.target    <= '0;
			sample_ch.time_step <= '0;
			sample_ch.restart   <= 1'b0;
		end else begin
			next_valid = sample_ch.valid;
			if (sample_ch.valid && sample_ch.ready) begin
				expected_positions.push_back(advance_follower(offered));
				samples_taken++;
				if (offered.restart)
					restarts_taken++;
				else if (offered.time_step == 0)
					zero_steps_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					offered = pending_samples.pop_front();
					sample_ch.target    <= offered.target;
					sample_ch.time_step <= offered.time_step;
					sample_ch.restart   <= offered.restart;
					next_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						case ($urandom_range(0, 3))
							1:       gap_left = $urandom_range(1, 4);
							2:       gap_left = $urandom_range(5, 60);
							default: gap_left = 0;
						endcase
					end
				end
			end
			sample_ch.valid <= next_valid;
		end
	end

	// Result receiver: changing stall pattern plus a few long hold-offs
	rcv_mode_t rcv_mode   = RCV_STEADY;
	int pattern_left      = 0;
	int third_tick        = 0;
	int results_taken     = 0;
	int long_hold_left    = 0;
	int long_hold_mark    = 130;
	logic next_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				results_taken++;
			if (pattern_left == 0) begin
				rcv_mode     = rcv_mode_t'($urandom_range(0, 2));
				pattern_left = $urandom_range(32, 256);
			end else begin
				pattern_left--;
			end
			third_tick = (third_tick == 2) ? 0 : third_tick + 1;
			if (long_hold_left > 0) begin
				long_hold_left--;
				next_ready = 1'b0;
			end else if (results_taken >= long_hold_mark) begin
				long_hold_left = LONG_HOLD;
				long_hold_mark = long_hold_mark + 900;
				next_ready = 1'b0;
			end else begin
				case (rcv_mode)
					RCV_STEADY: next_ready = 1'b1;
					RCV_COIN:   next_ready = 1'($urandom_range(0, 1));
					default:    next_ready = (third_tick == 0);
				endcase
			end
			result_ch.ready <= next_ready;
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_positions.size() == 0) begin
				$error("result with none pending: position %0d saturated %0b",
					$signed(result_ch.position), result_ch.saturated);
				failures++;
			end else begin
				due_result = expected_positions.pop_front();
				results_checked++;
				if (result_ch.saturated)
					saturated_seen++;
				if (result_ch.position !== due_result.position) begin
					$error("position: expected %0d, got %0d",
						$signed(due_result.position), $signed(result_ch.position));
					failures++;
				end
				if (result_ch.saturated !== due_result.saturated) begin
					$error("saturated: expected %0b, got %0b",
						due_result.saturated, result_ch.saturated);
					failures++;
				end
			end
		end
	end

	// Watchdog: cycles without any accepted request
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("stalled for %0d cycles with %0d results outstanding",
			quiet_cycles, expected_positions.size());
		$display("second_order_dynamics_follower regression: fail");
		$finish;
	end

	// Stimulus and run control
	initial begin
		int walk, span, len, phase_start;
		logic [15:0] dt;
		logic [31:0] k1, inv_k2, k3;

		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset gains: from the cleared state
		queue_sample(32'sh0000_0000, 16'h8000, 1'b0);
		queue_sample(32'sh0001_0000, 16'h8000, 1'b0);
		queue_sample(32'sh7FFF_FFFF, 16'h0001, 1'b0);
		wait_until_idle();

		// directed corners with k1 = 2.0, 1/k2 = 4.0, k3 = 1.0
		set_gains(32'h0002_0000, 32'h0004_0000, 32'h0001_0000);
		queue_sample(32'sh0000_0000, 16'h1000, 1'b1);
		queue_sample(32'sh000A_0000, 16'h1000, 1'b0);
		queue_sample(32'sh000A_0000, 16'h1000, 1'b0);
		queue_sample(32'sh000A_0000, 16'h0000, 1'b0);   // zero step
		queue_sample(32'sh7FFF_FFFF, 16'h0001, 1'b0);   // target rate clamps
		queue_sample(32'sh8000_0000, 16'h0001, 1'b0);   // rate and force clamp
		repeat (4)
			queue_sample(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);  // velocity, then position clamp
		queue_sample(32'sh7FFF_FFFF, 16'h0000, 1'b1);
		repeat (2)
			queue_sample(32'sh8000_0000, 16'hFFFF, 1'b0);
		queue_sample(32'sh8000_0000, 16'hFFFF, 1'b1);
		repeat (2)
			queue_sample(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
		queue_sample(-32'sd1, 16'hFFFF, 1'b0);
		queue_sample(32'sh0000_0000, 16'h0000, 1'b0);
		wait_until_idle();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			k1     = $urandom_range(0, 32'h0006_0000);
			inv_k2 = $urandom_range(32'h0000_0100, 32'h0010_0000);
			k3     = int'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
			case (phase)
				0: begin k1 = '0; inv_k2 = '0; k3 = '0; end
				1: begin k1 = 32'hFFFF_FFFF; inv_k2 = 32'hFFFF_FFFF; k3 = 32'h7FFF_FFFF; end
				2: k3 = 32'h8000_0000;
				3: begin k1 = $urandom; inv_k2 = $urandom; k3 = $urandom; end
				default: ;
			endcase
			set_gains(k1, inv_k2, k3);

			phase_start = queued_samples;
			while (queued_samples - phase_start < PHASE_SAMPLES) begin
				if ($urandom_range(0, 4) != 0) begin
					// restart, then a smooth target track with the odd jump
					walk = int'($urandom) >>> $urandom_range(4, 12);
					queue_sample(walk, 16'($urandom), 1'b1);
					len  = $urandom_range(4, 40);
					span = $urandom_range(4, 20);
					repeat (len) begin
						if ($urandom_range(0, 9) == 0)
							walk = int'($urandom) >>> 6;
						else
							walk = walk + int'($urandom_range(0, 1 << span)) - (1 << (span - 1));
						dt = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(64, 4096))
							: 16'($urandom_range(1, 65535));
						queue_sample(walk, dt, 1'b0);
					end
				end else begin
					// unrelated samples over the full field ranges
					repeat ($urandom_range(1, 6)) begin
						dt = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
						queue_sample($urandom, dt, $urandom_range(0, 7) == 0);
					end
				end
			end
			wait_until_idle();
		end

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_positions.size() != 0) begin
			$error("%0d results never arrived", expected_positions.size());
			failures++;
		end
		$display("%0d samples taken: %0d restarts, %0d zero steps; %0d register writes",
			samples_taken, restarts_taken, zero_steps_taken, register_writes);
		$display("%0d positions checked, %0d clamped; %0d mismatches",
			results_checked, saturated_seen, failures);
		if (failures == 0)
			$display("second_order_dynamics_follower regression: pass");
		else
			$display("second_order_dynamics_follower regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
